// ===== rtl/core/epe_pkg.sv =====
package epe_pkg;

	// Series store geometry
	localparam int MAX_SAMPLES = 1024;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = ADDR_W + 1;

	// Field and arithmetic widths
	localparam int SAMPLE_W  = 32;
	localparam int FRAC_W    = 16;
	localparam int SCALED_W  = FRAC_W + CNT_W;
	localparam int SUM_W     = 43;
	localparam int PROD_W    = SAMPLE_W + CNT_W + 1;
	localparam int DIFF_W    = PROD_W + 1;
	localparam int MARKS     = 3;
	localparam int MARK_IDX_W = 2;

	localparam logic [FRAC_W-1:0] FRAC_RESET = 16'h8000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_value;
		logic                       last_sample;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0] equilibration_index;
		logic             overflow_flag;
	} out_t;

	// Controller to datapath commands
	typedef struct packed {
		logic write;
		logic setup_mul;
		logic setup_idx;
		logic issue_sum;
		logic start_scan;
		logic issue_scan;
		logic finish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic addr_last;
		logic scan_busy;
		logic out_pending;
	} sts_t;

endpackage

// ===== rtl/core/epe_ram.sv =====
module epe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/epe_ctrl.sv =====
module epe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	input  epe_pkg::sts_t sts,
	output epe_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		LOAD,
		MUL,
		SET,
		SUM,
		SCAN_INIT,
		SCAN,
		DRAIN,
		FINISH
	} state_t;

	state_t state_q;
	logic   accept;

	// Hold off a series end while the previous result still waits
	assign in_ready = (state_q == LOAD) && !(sts.out_pending && in_last);
	assign accept   = in_valid && in_ready;

	// Decode commands from state
	always_comb begin
		cmd            = '0;
		cmd.write      = accept;
		cmd.setup_mul  = (state_q == MUL);
		cmd.setup_idx  = (state_q == SET);
		cmd.issue_sum  = (state_q == SUM);
		cmd.start_scan = (state_q == SCAN_INIT);
		cmd.issue_scan = (state_q == SCAN);
		cmd.finish     = (state_q == FINISH);
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
		end else begin
			unique case (state_q)
				LOAD: begin
					if (accept && in_last) begin
						state_q <= MUL;
					end
				end
				MUL:       state_q <= SET;
				SET:       state_q <= SUM;
				SUM: begin
					if (sts.addr_last) begin
						state_q <= SCAN_INIT;
					end
				end
				SCAN_INIT: state_q <= SCAN;
				SCAN: begin
					if (sts.addr_last) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					if (!sts.scan_busy) begin
						state_q <= FINISH;
					end
				end
				FINISH:    state_q <= LOAD;
				default:   state_q <= LOAD;
			endcase
		end
	end

endmodule

// ===== rtl/core/epe_datapath.sv =====
module epe_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [epe_pkg::FRAC_W-1:0]   cfg_data,
	input  epe_pkg::in_t                 in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output epe_pkg::out_t                out_data,
	input  epe_pkg::cmd_t                cmd,
	output epe_pkg::sts_t                sts
);

	localparam int CNT_W    = epe_pkg::CNT_W;
	localparam int ADDR_W   = epe_pkg::ADDR_W;
	localparam int SAMPLE_W = epe_pkg::SAMPLE_W;
	localparam int FRAC_W   = epe_pkg::FRAC_W;
	localparam int SCALED_W = epe_pkg::SCALED_W;
	localparam int SUM_W    = epe_pkg::SUM_W;
	localparam int PROD_W   = epe_pkg::PROD_W;
	localparam int DIFF_W   = epe_pkg::DIFF_W;
	localparam int MARKS    = epe_pkg::MARKS;
	localparam int MIDX_W   = epe_pkg::MARK_IDX_W;

	logic [FRAC_W-1:0]        frac_q;
	logic [CNT_W-1:0]         count_q;
	logic                     dropped_q;
	logic [SCALED_W-1:0]      scaled_q;
	logic [CNT_W-1:0]         n_q;
	logic [CNT_W-1:0]         m_q;
	logic [CNT_W-1:0]         rd_addr_q;
	logic signed [SUM_W-1:0]  tail_sum_q;
	logic [CNT_W-1:0]         mark_q [MARKS];
	logic [MIDX_W-1:0]        found_q;
	logic                     prev_pos_q;
	logic                     prev_neg_q;
	logic                     out_valid_q;
	epe_pkg::out_t            out_q;

	logic                     sum_s1;
	logic                     scan_s1;
	logic [CNT_W-1:0]         idx_s1;
	logic                     scan_s2;
	logic [CNT_W-1:0]         idx_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic                     full;
	logic                     ram_we;
	logic [SAMPLE_W-1:0]      rd_data;
	logic signed [SAMPLE_W-1:0] rd_signed;
	logic signed [CNT_W:0]    m_signed;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [DIFF_W-1:0] diff_d;
	logic                     pos;
	logic                     neg;
	logic                     crossing;
	logic [CNT_W-1:0]         idx_start;
	logic [CNT_W-1:0]         result;

	assign full      = (count_q == CNT_W'(epe_pkg::MAX_SAMPLES));
	assign ram_we    = cmd.write && !full;
	assign idx_start = scaled_q[SCALED_W-1 -: CNT_W];

	epe_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(epe_pkg::MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(in_data.sample_value),
		.raddr(rd_addr_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	// Side test: sample * m against the tail sum
	assign rd_signed = rd_data;
	assign m_signed  = {1'b0, m_q};
	assign prod_d    = rd_signed * m_signed;
	assign diff_d    = DIFF_W'(prod_s2) - DIFF_W'(tail_sum_q);
	assign neg       = diff_d[DIFF_W-1];
	assign pos       = !diff_d[DIFF_W-1] && (diff_d != '0);
	assign crossing  = scan_s2 && ((pos && prev_neg_q) || (neg && prev_pos_q));

	// Clamp the third crossing against frac * n
	assign result = (SCALED_W'({mark_q[MARKS-1], FRAC_W'(0)}) > scaled_q)
		? idx_start : mark_q[MARKS-1];

	assign sts.addr_last   = (rd_addr_q == n_q - CNT_W'(1));
	assign sts.scan_busy   = scan_s1 || scan_s2;
	assign sts.out_pending = out_valid_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q      <= epe_pkg::FRAC_RESET;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			sum_s1      <= 1'b0;
			scan_s1     <= 1'b0;
			scan_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				frac_q <= cfg_data;
			end
			// Store the sample, or drop it and flag when full
			if (cmd.finish) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end else if (cmd.write) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			sum_s1  <= cmd.issue_sum;
			scan_s1 <= cmd.issue_scan;
			scan_s2 <= scan_s1;
			// Output register: set on finish, drop on transaction
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Evaluation datapath
	always_ff @(posedge clk) begin
		if (cmd.setup_mul) begin
			scaled_q <= SCALED_W'(frac_q) * SCALED_W'(count_q);
			n_q      <= count_q;
		end
		if (cmd.setup_idx) begin
			m_q        <= n_q - idx_start;
			rd_addr_q  <= idx_start;
			tail_sum_q <= '0;
		end else if (cmd.start_scan) begin
			rd_addr_q <= '0;
		end else if (cmd.issue_sum || cmd.issue_scan) begin
			rd_addr_q <= rd_addr_q + CNT_W'(1);
		end
		idx_s1 <= rd_addr_q;

		// Accumulate the tail
		if (sum_s1) begin
			tail_sum_q <= tail_sum_q + SUM_W'(rd_signed);
		end

		idx_s2  <= idx_s1;
		prod_s2 <= prod_d;

		// Record the first three crossings
		if (cmd.start_scan) begin
			found_q    <= '0;
			prev_pos_q <= 1'b0;
			prev_neg_q <= 1'b0;
			for (int k = 0; k < MARKS; k++) begin
				mark_q[k] <= n_q;
			end
		end else if (scan_s2) begin
			prev_pos_q <= pos;
			prev_neg_q <= neg;
			if (crossing && (found_q != MIDX_W'(MARKS))) begin
				mark_q[found_q] <= idx_s2 - CNT_W'(1);
				found_q         <= found_q + MIDX_W'(1);
			end
		end

		if (cmd.finish) begin
			out_q.equilibration_index <= result;
			out_q.overflow_flag       <= dropped_q;
		end
	end

endmodule

// ===== rtl/core/equilibration_point_estimator_unit.sv =====
// Equilibration point estimator.
// Input channel (in_valid/in_ready/in_data) takes one signed Q16.16 sample per
// transaction; a transaction with last_sample set closes the series. Samples
// load one per cycle into a 1024-entry store; samples past a full store are
// dropped and reported through overflow_flag.
// Config channel (cfg_valid/cfg_ready/cfg_data) writes burn_in_fraction; it is
// always ready and is read when the series closes.
// After the closing sample the block runs a tail summing pass over the store
// (n - idx reads, with idx = floor(frac * n / 65536)), then a crossing scan
// over all n samples, through the single store read port. No samples are taken
// until out_valid rises.
// Output channel (out_valid/out_ready/out_data) carries one result per series
// from an output register. A stalled receiver does not block loading the next
// series; only its closing sample waits until the pending result is taken.
// Reset clears the sample count, overflow flag and output valid and sets the
// fraction to one half; store contents are not cleared.
module equilibration_point_estimator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [epe_pkg::FRAC_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  epe_pkg::in_t               in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output epe_pkg::out_t              out_data
);

	epe_pkg::cmd_t cmd;
	epe_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	epe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_last (in_data.last_sample),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	epe_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
